// File: hw/rtl/wpce_pkg.sv
// shared types and constants for the walsh pilot channel estimator
package wpce_pkg;

   localparam int NUM_TX      = 3;
   localparam int TX_W        = 2;
   localparam int ROW_W       = 8;
   localparam int EST_W       = 17;
   localparam int RSP_TDATA_W = 40;
   localparam int INV_SQRT2_Q16 = 46341;
   localparam int EST_MAX     = 65535;
   localparam int EST_MIN     = -65536;
   localparam int Q16_SHIFT   = 16;

   typedef enum logic [1:0] {
      CSR_ROW_TX0 = 2'd0,
      CSR_ROW_TX1 = 2'd1,
      CSR_ROW_TX2 = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   typedef enum logic [TX_W-1:0] {
      TX0 = 2'd0,
      TX1 = 2'd1,
      TX2 = 2'd2
   } tx_type;

   typedef logic [NUM_TX-1:0][ROW_W-1:0] rows_type;

endpackage

// File: hw/rtl/wpce_corr.sv
// symbol counter and pilot correlation accumulators
module wpce_corr import wpce_pkg::*; #(
   parameter int NUM_PILOTS   = 16,
   parameter int SAMPLE_WIDTH = 16,
   parameter int ACC_W        = SAMPLE_WIDTH + 2 + $clog2(NUM_PILOTS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_re,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_im,
   input  rows_type                       rows,
   output logic                           last_sym,
   output logic                           grp_done,
   output logic [NUM_TX-1:0][ACC_W-1:0]   grp_re,
   output logic [NUM_TX-1:0][ACC_W-1:0]   grp_im
);

   localparam int CNT_W  = $clog2(NUM_PILOTS);
   localparam int TERM_W = SAMPLE_WIDTH + 2;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] acc_re_ff [NUM_TX];
   logic signed [ACC_W-1:0] acc_im_ff [NUM_TX];
   logic signed [ACC_W-1:0] sum_re [NUM_TX];
   logic signed [ACC_W-1:0] sum_im [NUM_TX];
   logic [CNT_W-1:0] mir;
   logic [ROW_W-1:0] s8, m8;
   logic signed [TERM_W-1:0] re_x, im_x;

   assign last_sym = (cnt_ff == CNT_W'(NUM_PILOTS - 1));
   assign grp_done = fire && last_sym;
   assign mir      = CNT_W'(NUM_PILOTS - 1) - cnt_ff;
   assign s8       = ROW_W'(cnt_ff);
   assign m8       = ROW_W'(mir);
   assign re_x     = TERM_W'(rx_re);
   assign im_x     = TERM_W'(rx_im);
   assign cnt_in   = last_sym ? '0 : cnt_ff + 1'b1;

   always_comb begin
      for (int t = 0; t < NUM_TX; t++) begin
         logic sa, sb;
         logic signed [TERM_W-1:0] tre, tim;
         sa = ^(rows[t] & s8);
         sb = ^(rows[t] & m8);
         // conj(chip) * sample without the 1/sqrt2 factor
         tre = (sa ? -re_x : re_x) + (sb ? -im_x : im_x);
         tim = (sa ? -im_x : im_x) + (sb ? re_x : -re_x);
         sum_re[t] = acc_re_ff[t] + ACC_W'(tre);
         sum_im[t] = acc_im_ff[t] + ACC_W'(tim);
         grp_re[t] = sum_re[t];
         grp_im[t] = sum_im[t];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int t = 0; t < NUM_TX; t++) begin
            acc_re_ff[t] <= '0;
            acc_im_ff[t] <= '0;
         end
      end else if (fire) begin
         cnt_ff <= cnt_in;
         for (int t = 0; t < NUM_TX; t++) begin
            acc_re_ff[t] <= last_sym ? '0 : sum_re[t];
            acc_im_ff[t] <= last_sym ? '0 : sum_im[t];
         end
      end
   end

endmodule

// File: hw/rtl/wpce_out.sv
// group snapshot, estimate scaling and result register
module wpce_out import wpce_pkg::*; #(
   parameter int NUM_PILOTS   = 16,
   parameter int ACC_W        = 22
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         grp_done,
   input  logic [NUM_TX-1:0][ACC_W-1:0] grp_re,
   input  logic [NUM_TX-1:0][ACC_W-1:0] grp_im,
   output logic                         busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [EST_W-1:0]      est_re,
   output logic signed [EST_W-1:0]      est_im,
   output logic [TX_W-1:0]              tx_index,
   output logic                         last
);

   localparam int SH     = Q16_SHIFT + $clog2(NUM_PILOTS + 1) - 1;
   localparam int PROD_W = ACC_W + 18;
   localparam logic signed [PROD_W-1:0] ROUND_K = PROD_W'(1) << (SH - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(EST_MAX);
   localparam logic signed [PROD_W-1:0] SAT_LO  = PROD_W'(EST_MIN);
   localparam logic signed [17:0]       K_SCALE = 18'(INV_SQRT2_Q16);

   logic signed [ACC_W-1:0] snap_re_ff [NUM_TX];
   logic signed [ACC_W-1:0] snap_im_ff [NUM_TX];
   logic                    busy_ff, busy_in;
   logic [TX_W-1:0]         idx_ff;
   logic                    valid_ff;
   logic signed [EST_W-1:0] re_ff, im_ff, re_in, im_in;
   logic [TX_W-1:0]         tx_ff;
   logic                    last_ff;
   logic                    out_free, emit;

   function automatic logic signed [EST_W-1:0] scale_est(input logic signed [ACC_W-1:0] a);
      logic signed [PROD_W-1:0] p;
      logic signed [PROD_W-1:0] r;
      p = PROD_W'(a) * PROD_W'(K_SCALE) + ROUND_K;
      r = p >>> SH;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end
      if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return EST_W'(r);
   endfunction

   assign out_free = !valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign re_in    = scale_est(snap_re_ff[idx_ff]);
   assign im_in    = scale_est(snap_im_ff[idx_ff]);

   always_comb begin
      busy_in = busy_ff;
      if (grp_done) begin
         busy_in = 1'b1;
      end else if (emit && idx_ff == TX2) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= TX0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (grp_done) begin
            idx_ff <= TX0;
         end else if (emit) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (out_free) begin
            valid_ff <= busy_ff;
         end
      end
      if (grp_done) begin
         for (int t = 0; t < NUM_TX; t++) begin
            snap_re_ff[t] <= grp_re[t];
            snap_im_ff[t] <= grp_im[t];
         end
      end
      if (emit) begin
         re_ff   <= re_in;
         im_ff   <= im_in;
         tx_ff   <= idx_ff;
         last_ff <= (idx_ff == TX2);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign est_re    = re_ff;
   assign est_im    = im_ff;
   assign tx_index  = tx_ff;
   assign last      = last_ff;

endmodule

// File: hw/rtl/walsh_pilot_channel_estimator.sv
// top level of the walsh-hadamard pilot channel estimator
//
//  channel | dir | handshake         | payload
//  req     | in  | tvalid / tready   | tdata: rx_re, rx_im
//  rsp     | out | tvalid / tready   | tdata: est_re, est_im; tuser: tx_index; tlast: last
//  csr     | in  | write             | index, data (8-bit code rows)
//
// one request is taken per cycle while req_tready is high; a group of NUM_PILOTS
// requests yields three responses, which leave one per cycle from the result
// register while rsp_tready is high. the request that closes a group waits
// until the single snapshot buffer has handed the prior group's three to the result register.
// reset clears the symbol counter, accumulators and code rows to 0, 1, 2.
module walsh_pilot_channel_estimator import wpce_pkg::*; #(
   parameter int NUM_PILOTS   = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // rx_re, rx_im
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // est_re, est_im
   output logic [RSP_TDATA_W-1:0]                  rsp_tdata,
   // tx_index
   output logic [TX_W-1:0]                         rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_write,
   input  logic [1:0]                              csr_index,
   input  logic [ROW_W-1:0]                        csr_data
);

   localparam int ACC_W = SAMPLE_WIDTH + 2 + $clog2(NUM_PILOTS);

   rows_type                     rows_ff;
   logic                         req_fire;
   logic                         last_sym, grp_done, busy;
   logic [NUM_TX-1:0][ACC_W-1:0] grp_re, grp_im;
   logic signed [EST_W-1:0]      est_re, est_im;
   logic                         rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0] <= ROW_W'(0);
         rows_ff[1] <= ROW_W'(1);
         rows_ff[2] <= ROW_W'(2);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_TX0: rows_ff[0] <= csr_data;
            CSR_ROW_TX1: rows_ff[1] <= csr_data;
            CSR_ROW_TX2: rows_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !last_sym || !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   wpce_corr #(
      .NUM_PILOTS  (NUM_PILOTS),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .ACC_W       (ACC_W)
   ) u_corr (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .rx_re   (req_tdata[SAMPLE_WIDTH-1:0]),
      .rx_im   (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .rows    (rows_ff),
      .last_sym(last_sym),
      .grp_done(grp_done),
      .grp_re  (grp_re),
      .grp_im  (grp_im)
   );

   wpce_out #(
      .NUM_PILOTS(NUM_PILOTS),
      .ACC_W     (ACC_W)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .grp_done (grp_done),
      .grp_re   (grp_re),
      .grp_im   (grp_im),
      .busy     (busy),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .est_re   (est_re),
      .est_im   (est_im),
      .tx_index (rsp_tuser),
      .last     (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 2*EST_W)'(0), est_im, est_re};

   // a closed group always leaves the snapshot buffer busy
   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      grp_done |=> busy)
      else $error("snapshot buffer not busy after group end");

   // tlast marks exactly the third transmitter
   a_last_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == TX2)))
      else $error("tlast does not match tx index");

   // a group never closes while the snapshot buffer still holds the previous one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy && last_sym |-> !req_fire)
      else $error("group closed while snapshot busy");

   // responses keep transmitter order
   a_tx_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tuser == TX0 |=> !rsp_tvalid || rsp_tuser == TX1)
      else $error("transmitter order broken");

endmodule

// File: bench/wpce_estimate_checker.sv
// checker for the walsh pilot channel estimator: predicts estimates and compares responses
`timescale 1ns / 1ps

module wpce_estimate_checker import wpce_pkg::*; #(
   parameter int NUM_PILOTS   = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [RSP_TDATA_W-1:0]              rsp_tdata,
   input  logic [TX_W-1:0]                     rsp_tuser,
   input  logic                                rsp_tlast,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [ROW_W-1:0]                    csr_data,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int REQ_W       = ((2*SAMPLE_WIDTH+7)/8)*8;
   localparam int LOG2_PILOTS = $clog2(NUM_PILOTS + 1) - 1;
   localparam int SCALE_SHIFT = Q16_SHIFT + LOG2_PILOTS;

   typedef struct packed {
      logic signed [EST_W-1:0] re;
      logic signed [EST_W-1:0] im;
      tx_type                  tx;
      logic                    last;
   } estimate_type;

   estimate_type     est_queue[$];
   logic [ROW_W-1:0] code_row[NUM_TX];
   longint           corr_re[NUM_TX];
   longint           corr_im[NUM_TX];
   int               symbol_idx;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   function automatic logic signed [EST_W-1:0] scale_to_est(input longint acc);
      longint p;
      longint r;
      p = acc * INV_SQRT2_Q16 + (longint'(1) <<< (SCALE_SHIFT - 1));
      r = p >>> SCALE_SHIFT;
      if (r > EST_MAX) r = EST_MAX;
      if (r < EST_MIN) r = EST_MIN;
      return r[EST_W-1:0];
   endfunction

   task automatic accumulate_sample(input logic [REQ_W-1:0] data);
      logic signed [SAMPLE_WIDTH-1:0] re_raw;
      logic signed [SAMPLE_WIDTH-1:0] im_raw;
      longint    re;
      longint    im;
      longint    a;
      longint    b;
      logic [31:0] sidx;
      logic [31:0] mirror;
      estimate_type e;
      re_raw = data[SAMPLE_WIDTH-1:0];
      im_raw = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      re     = longint'(re_raw);
      im     = longint'(im_raw);
      sidx   = symbol_idx;
      mirror = NUM_PILOTS - 1 - symbol_idx;
      for (int t = 0; t < NUM_TX; t++) begin
         a = (^({24'd0, code_row[t]} & sidx)) ? -1 : 1;
         b = (^({24'd0, code_row[t]} & mirror)) ? -1 : 1;
         corr_re[t] += re * a + im * b;
         corr_im[t] += im * a - re * b;
      end
      symbol_idx++;
      if (symbol_idx == NUM_PILOTS) begin
         symbol_idx = 0;
         for (int t = 0; t < NUM_TX; t++) begin
            e.re   = scale_to_est(corr_re[t]);
            e.im   = scale_to_est(corr_im[t]);
            e.tx   = tx_type'(t);
            e.last = (t == NUM_TX - 1);
            est_queue.push_back(e);
            corr_re[t] = 0;
            corr_im[t] = 0;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      estimate_type            want;
      logic signed [EST_W-1:0] got_re;
      logic signed [EST_W-1:0] got_im;
      if (reset) begin
         code_row[0] = 8'd0;
         code_row[1] = 8'd1;
         code_row[2] = 8'd2;
         symbol_idx  = 0;
         for (int t = 0; t < NUM_TX; t++) begin
            corr_re[t] = 0;
            corr_im[t] = 0;
         end
         est_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_re = rsp_tdata[EST_W-1:0];
            got_im = rsp_tdata[2*EST_W-1:EST_W];
            if (est_queue.size() == 0) begin
               report_mismatch($sformatf("response with no estimate pending, tx %0d est %0d/%0d",
                                         rsp_tuser, got_re, got_im));
            end else begin
               want = est_queue.pop_front();
               if (got_re !== want.re)
                  report_mismatch($sformatf("tx %0d est_re got %0d expected %0d",
                                            want.tx, got_re, longint'(want.re)));
               if (got_im !== want.im)
                  report_mismatch($sformatf("tx %0d est_im got %0d expected %0d",
                                            want.tx, got_im, longint'(want.im)));
               if (rsp_tdata[RSP_TDATA_W-1:2*EST_W] !== '0)
                  report_mismatch($sformatf("tx %0d tdata padding not zero: %h",
                                            want.tx, rsp_tdata[RSP_TDATA_W-1:2*EST_W]));
               if (rsp_tuser !== want.tx)
                  report_mismatch($sformatf("tx_index got %0d expected %0d",
                                            rsp_tuser, want.tx));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tx %0d last got %0d expected %0d",
                                            want.tx, rsp_tlast, want.last));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ROW_TX0: code_row[0] = csr_data;
               CSR_ROW_TX1: code_row[1] = csr_data;
               CSR_ROW_TX2: code_row[2] = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            accumulate_sample(req_tdata);
      end
      pending <= est_queue.size();
   end

endmodule

// File: bench/tb_walsh_pilot_channel_estimator.sv
// stimulus and verdict for the walsh pilot channel estimator testbench
`timescale 1ns / 1ps

module tb_walsh_pilot_channel_estimator;
   import wpce_pkg::*;

   localparam int NUM_PILOTS    = 16;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int REQ_W         = ((2*SAMPLE_WIDTH+7)/8)*8;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int STUCK_LIMIT   = 3000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [TX_W-1:0]        rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_write;
   logic [1:0]             csr_index;
   logic [ROW_W-1:0]       csr_data;

   int fail_count;
   int pending;
   int stuck_cycles;
   bit tx_idle;
   bit rx_idle;
   bit long_hold;

   walsh_pilot_channel_estimator #(
      .NUM_PILOTS   (NUM_PILOTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   wpce_estimate_checker #(
      .NUM_PILOTS   (NUM_PILOTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STUCK_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // receiver: random ready bursts and the long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 127)) - 64);
         3: return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] re,
                              input logic [SAMPLE_WIDTH-1:0] im);
      int gap;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_estimates_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ROW_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [ROW_W-1:0] row0, input logic [ROW_W-1:0] row1,
                            input logic [ROW_W-1:0] row2, input int count,
                            input bit sender_idles, input bit receiver_idles,
                            input bit hold_off);
      wait_estimates_drained();
      write_csr(CSR_ROW_TX0, row0);
      write_csr(CSR_ROW_TX1, row1);
      write_csr(CSR_ROW_TX2, row2);
      write_csr(CSR_UNUSED, ROW_W'($urandom));
      tx_idle = sender_idles;
      rx_idle = receiver_idles;
      if (hold_off) long_hold = 1'b1;
      repeat (count) send_sample(random_sample(), random_sample());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_write  = 1'b0;
      csr_index  = CSR_ROW_TX0;
      csr_data   = '0;
      tx_idle    = 1'b1;
      rx_idle    = 1'b1;
      long_hold  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full-scale negative group on reset rows, then extremes
      repeat (NUM_PILOTS) send_sample(16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hffff, 16'hffff);
      send_sample(16'h0001, 16'hffff);
      send_sample(16'h8000, 16'h0000);
      send_sample(16'h0000, 16'h7fff);
      send_sample(16'h5555, 16'haaaa);

      run_phase(8'd255, 8'd0, 8'd128, 64, 1'b1, 1'b1, 1'b0);
      // rows with bits above the pilot length; receiver holds off
      run_phase(8'd15, 8'd16, 8'd240, 72, 1'b1, 1'b1, 1'b1);
      run_phase(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom), 40, 1'b1, 1'b0, 1'b0);
      run_phase(8'd0, 8'd0, 8'd0, 56, 1'b0, 1'b1, 1'b0);
      run_phase(8'd255, 8'd255, 8'd255, 48, 1'b1, 1'b1, 1'b0);
      run_phase(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom), 50, 1'b1, 1'b1, 1'b0);
      run_phase(8'd170, 8'd85, 8'd3, 75, 1'b0, 1'b0, 1'b0);

      wait_estimates_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
